// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is low
`define QRM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrm assertion failed");

// clocked assertion that also holds during reset
`define QRM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("qrm reset assertion failed");

`endif

// ===== sv/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// shared widths and pipeline payload types of the quaternion to matrix block
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int QW        = 18;  // quaternion component width
  localparam int PW        = 36;  // product width
  localparam int SW        = 38;  // signed sum width
  localparam int DW        = 37;  // divisor (squared norm) width
  localparam int RW        = 38;  // partial remainder width
  localparam int QOW       = 16;  // quotient width (two times the result)
  localparam int EW        = 16;  // rotation entry width
  localparam int TW        = 32;  // translation width
  localparam int LANES     = 9;
  localparam int DIV_STG   = 5;
  localparam int DIV_BITS  = 3;
  localparam int NSTG      = DIV_STG + 3;
  localparam logic signed [EW-1:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic            neg;
    logic [RW-1:0]   rem;
    logic [QOW-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic                   zero;
    logic [DW-1:0]          den;
    lane_t [LANES-1:0]      lane;
  } dv_t;

endpackage

// ===== sv/qrm_prep.sv =====
// ----------------------------------------------------------------------------
// qrm_prep
// products of the quaternion components, then norm, numerators and first
// quotient bit of every entry
// ----------------------------------------------------------------------------
module qrm_prep (
  input  logic                            clk,
  input  logic                            ld0,
  input  logic                            ld1,
  input  logic signed [qrm_pkg::QW-1:0]   quat_x,
  input  logic signed [qrm_pkg::QW-1:0]   quat_y,
  input  logic signed [qrm_pkg::QW-1:0]   quat_z,
  input  logic signed [qrm_pkg::QW-1:0]   quat_w,
  output qrm_pkg::dv_t                    dv
);
  import qrm_pkg::*;

  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r;
  logic signed [PW-1:0] xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic signed [SW-1:0] nn, t0, t4, t8;
  logic signed [SW-1:0] p1, p2, p4, p6, p8, p9;
  dv_t                  dv_nxt, dv_r;

  // magnitude of the numerator; first quotient bit is set only when it equals the norm
  function automatic lane_t mk_lane(input logic signed [SW-1:0] v, input logic dbl,
                                    input logic [DW-1:0] den);
    logic [SW-1:0] mag;
    logic [DW-1:0] a;
    lane_t         l;
    mag   = v[SW-1] ? SW'(-v) : SW'(v);
    a     = dbl ? DW'(mag << 1) : DW'(mag);
    l.neg = v[SW-1];
    if (a == den) begin
      l.rem = '0;
      l.quo = QOW'(1);
    end else begin
      l.rem = RW'(a);
      l.quo = '0;
    end
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (ld0) begin
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      zz_r <= quat_z * quat_z;
      ww_r <= quat_w * quat_w;
      xy_r <= quat_x * quat_y;
      xz_r <= quat_x * quat_z;
      yz_r <= quat_y * quat_z;
      wx_r <= quat_w * quat_x;
      wy_r <= quat_w * quat_y;
      wz_r <= quat_w * quat_z;
    end
  end

  always_comb begin
    nn = SW'(xx_r) + SW'(yy_r) + SW'(zz_r) + SW'(ww_r);
    t0 = nn - ((SW'(yy_r) + SW'(zz_r)) <<< 1);
    t4 = nn - ((SW'(xx_r) + SW'(zz_r)) <<< 1);
    t8 = nn - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
    p1 = SW'(xy_r) + SW'(wz_r);
    p2 = SW'(xz_r) - SW'(wy_r);
    p4 = SW'(xy_r) - SW'(wz_r);
    p6 = SW'(yz_r) + SW'(wx_r);
    p8 = SW'(xz_r) + SW'(wy_r);
    p9 = SW'(yz_r) - SW'(wx_r);
    dv_nxt.zero    = (nn == '0);
    dv_nxt.den     = DW'(nn);
    dv_nxt.lane[0] = mk_lane(t0, 1'b0, DW'(nn));
    dv_nxt.lane[1] = mk_lane(p1, 1'b1, DW'(nn));
    dv_nxt.lane[2] = mk_lane(p2, 1'b1, DW'(nn));
    dv_nxt.lane[3] = mk_lane(p4, 1'b1, DW'(nn));
    dv_nxt.lane[4] = mk_lane(t4, 1'b0, DW'(nn));
    dv_nxt.lane[5] = mk_lane(p6, 1'b1, DW'(nn));
    dv_nxt.lane[6] = mk_lane(p8, 1'b1, DW'(nn));
    dv_nxt.lane[7] = mk_lane(p9, 1'b1, DW'(nn));
    dv_nxt.lane[8] = mk_lane(t8, 1'b0, DW'(nn));
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv = dv_r;

endmodule

// ===== sv/qrm_div_stage.sv =====
// ----------------------------------------------------------------------------
// qrm_div_stage
// one stage of the restoring divider, three quotient bits for all nine lanes
// ----------------------------------------------------------------------------
module qrm_div_stage (
  input  logic          clk,
  input  logic          ld,
  input  qrm_pkg::dv_t  dv_in,
  output qrm_pkg::dv_t  dv_out
);
  import qrm_pkg::*;

  dv_t dv_nxt, dv_r;

  always_comb begin
    logic [RW-1:0] rs;
    dv_nxt = dv_in;
    for (int l = 0; l < LANES; l++) begin
      for (int b = 0; b < DIV_BITS; b++) begin
        rs = {dv_nxt.lane[l].rem[RW-2:0], 1'b0};
        if (rs >= RW'(dv_in.den)) begin
          dv_nxt.lane[l].rem = rs - RW'(dv_in.den);
          dv_nxt.lane[l].quo = {dv_nxt.lane[l].quo[QOW-2:0], 1'b1};
        end else begin
          dv_nxt.lane[l].rem = rs;
          dv_nxt.lane[l].quo = {dv_nxt.lane[l].quo[QOW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv_out = dv_r;

endmodule

// ===== sv/qrm_round.sv =====
// ----------------------------------------------------------------------------
// qrm_round
// halves the quotient with rounding, applies the sign, selects identity for
// a zero quaternion and holds the output register
// ----------------------------------------------------------------------------
module qrm_round (
  input  logic                          clk,
  input  logic                          ld,
  input  qrm_pkg::dv_t                  dv,
  output logic signed [qrm_pkg::EW-1:0] elem [qrm_pkg::LANES]
);
  import qrm_pkg::*;

  logic signed [EW-1:0] elem_nxt [LANES];
  logic signed [EW-1:0] elem_r   [LANES];

  always_comb begin
    logic [QOW:0]  qs;
    logic [EW-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      // ties away from zero on the magnitude; result is at most one, so no clipping
      qs = {1'b0, dv.lane[l].quo} + (QOW+1)'(1);
      q  = qs[QOW:1];
      if (dv.zero) begin
        elem_nxt[l] = (l == 0 || l == 4 || l == 8) ? ONE_Q14 : '0;
      end else begin
        elem_nxt[l] = dv.lane[l].neg ? -$signed(q) : $signed(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      elem_r <= elem_nxt;
    end
  end

  assign elem = elem_r;

endmodule

// ===== sv/quaternion_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// normalizes a Q3.14 quaternion and forms the nine Q1.14 rotation entries
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   in_quat_x..w, in_pos_x..z
//  out      out_valid / out_stall out_elem_*, out_trans_x..z
//
//  eight register stages: products, norm and numerators, five divider stages
//  of three quotient bits each, rounding and output register
//  one item per cycle while out_stall is low; the divider sets the depth
//  reset clears all stage valid bits, payload registers are not reset
//  each stage holds while the one after it is full and stalled, so bubbles
//  close up and in_stall rises only when every stage is full
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [qrm_pkg::QW-1:0]  in_quat_x,
  input  logic signed [qrm_pkg::QW-1:0]  in_quat_y,
  input  logic signed [qrm_pkg::QW-1:0]  in_quat_z,
  input  logic signed [qrm_pkg::QW-1:0]  in_quat_w,
  input  logic signed [qrm_pkg::TW-1:0]  in_pos_x,
  input  logic signed [qrm_pkg::TW-1:0]  in_pos_y,
  input  logic signed [qrm_pkg::TW-1:0]  in_pos_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_0,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_1,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_2,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_4,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_5,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_6,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_8,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_9,
  output logic signed [qrm_pkg::EW-1:0]  out_elem_10,
  output logic signed [qrm_pkg::TW-1:0]  out_trans_x,
  output logic signed [qrm_pkg::TW-1:0]  out_trans_y,
  output logic signed [qrm_pkg::TW-1:0]  out_trans_z
);
  import qrm_pkg::*;

  logic [NSTG-1:0]      vld_r;
  logic [NSTG-1:0]      en;
  logic signed [TW-1:0] px_r [NSTG];
  logic signed [TW-1:0] py_r [NSTG];
  logic signed [TW-1:0] pz_r [NSTG];
  dv_t                  dv [DIV_STG+1];
  logic signed [EW-1:0] elem [LANES];

  // a stage loads when empty or when the next one loads
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // translation rides along with the item
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r[0] <= in_pos_x;
      py_r[0] <= in_pos_y;
      pz_r[0] <= in_pos_z;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
        pz_r[k] <= pz_r[k-1];
      end
    end
  end

  qrm_prep u_prep (
    .clk    (clk),
    .ld0    (en[0]),
    .ld1    (en[1]),
    .quat_x (in_quat_x),
    .quat_y (in_quat_y),
    .quat_z (in_quat_z),
    .quat_w (in_quat_w),
    .dv     (dv[0])
  );

  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    qrm_div_stage u_div (
      .clk    (clk),
      .ld     (en[g+2]),
      .dv_in  (dv[g]),
      .dv_out (dv[g+1])
    );
  end

  qrm_round u_round (
    .clk  (clk),
    .ld   (en[NSTG-1]),
    .dv   (dv[DIV_STG]),
    .elem (elem)
  );

  assign out_valid   = vld_r[NSTG-1];
  assign out_elem_0  = elem[0];
  assign out_elem_1  = elem[1];
  assign out_elem_2  = elem[2];
  assign out_elem_4  = elem[3];
  assign out_elem_5  = elem[4];
  assign out_elem_6  = elem[5];
  assign out_elem_8  = elem[6];
  assign out_elem_9  = elem[7];
  assign out_elem_10 = elem[8];
  assign out_trans_x = px_r[NSTG-1];
  assign out_trans_y = py_r[NSTG-1];
  assign out_trans_z = pz_r[NSTG-1];

endmodule

// ===== sv/qrm_checker.sv =====
// ----------------------------------------------------------------------------
// qrm_checker
// port level checks of the quaternion to matrix block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qrm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic signed [qrm_pkg::QW-1:0]  in_quat_x,
  input logic signed [qrm_pkg::QW-1:0]  in_quat_y,
  input logic signed [qrm_pkg::QW-1:0]  in_quat_z,
  input logic signed [qrm_pkg::QW-1:0]  in_quat_w,
  input logic signed [qrm_pkg::TW-1:0]  in_pos_x,
  input logic signed [qrm_pkg::TW-1:0]  in_pos_y,
  input logic signed [qrm_pkg::TW-1:0]  in_pos_z,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_0,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_1,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_2,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_4,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_5,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_6,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_8,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_9,
  input logic signed [qrm_pkg::EW-1:0]  out_elem_10,
  input logic signed [qrm_pkg::TW-1:0]  out_trans_x,
  input logic signed [qrm_pkg::TW-1:0]  out_trans_y,
  input logic signed [qrm_pkg::TW-1:0]  out_trans_z
);
  import qrm_pkg::*;

  logic diag_ok;

  // diagonal entries of a rotation never leave [-1, 1]
  assign diag_ok = out_elem_0 >= -ONE_Q14 && out_elem_0 <= ONE_Q14 &&
                   out_elem_5 >= -ONE_Q14 && out_elem_5 <= ONE_Q14 &&
                   out_elem_10 >= -ONE_Q14 && out_elem_10 <= ONE_Q14;

  `QRM_ASSERT_RST(a_rst_clears, !rst_n |=> !out_valid)
  `QRM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `QRM_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_elem_1) && $stable(out_trans_x))
  `QRM_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall)
  `QRM_ASSERT(a_diag_range, out_valid |-> diag_ok)

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (.*);

// ===== sim/quaternion_to_rotation_matrix_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// streams quaternions and translations through the block under random input
// and output stalls and checks every rotation entry and the passed-through
// translation against an exact integer computation of the normalized matrix
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrm_pkg::*;

  typedef struct {
    logic signed [QW-1:0] qx, qy, qz, qw;
    logic signed [TW-1:0] px, py, pz;
  } pose_t;

  typedef struct {
    logic signed [EW-1:0] e [9];
    logic signed [TW-1:0] tx, ty, tz;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QW-1:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  logic signed [TW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [EW-1:0] out_elem_0, out_elem_1, out_elem_2, out_elem_4, out_elem_5;
  logic signed [EW-1:0] out_elem_6, out_elem_8, out_elem_9, out_elem_10;
  logic signed [TW-1:0] out_trans_x, out_trans_y, out_trans_z;

  pose_t  pose_q [$];
  xform_t matrix_q [$];
  int     errors = 0;
  int     send_idle_pct = 22;
  int     recv_idle_pct = 54;
  logic   hold_on = 1'b0;
  logic   in_taken = 1'b0;

  quaternion_to_rotation_matrix u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic logic signed [EW-1:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return EW'(v);
  endfunction

  function automatic xform_t rotation_of(pose_t p);
    xform_t m;
    longint x, y, z, w, xx, yy, zz, xy, xz, yz, wx, wy, wz, n;
    longint r [9];
    x = p.qx; y = p.qy; z = p.qz; w = p.qw;
    xx = x * x; yy = y * y; zz = z * z;
    xy = x * y; xz = x * z; yz = y * z;
    wx = w * x; wy = w * y; wz = w * z;
    n = xx + yy + zz + w * w;
    if (n == 0) begin
      r = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    end else begin
      r[0] = round_div((n - 2 * (yy + zz)) * 16384, n);
      r[1] = round_div((xy + wz) * 32768, n);
      r[2] = round_div((xz - wy) * 32768, n);
      r[3] = round_div((xy - wz) * 32768, n);
      r[4] = round_div((n - 2 * (xx + zz)) * 16384, n);
      r[5] = round_div((yz + wx) * 32768, n);
      r[6] = round_div((xz + wy) * 32768, n);
      r[7] = round_div((yz - wx) * 32768, n);
      r[8] = round_div((n - 2 * (xx + yy)) * 16384, n);
    end
    for (int i = 0; i < 9; i++) m.e[i] = sat16(r[i]);
    m.tx = p.px; m.ty = p.py; m.tz = p.pz;
    return m;
  endfunction

  task automatic push_pose(int x, int y, int z, int w);
    pose_t p;
    p.qx = QW'(x); p.qy = QW'(y); p.qz = QW'(z); p.qw = QW'(w);
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    pose_q.push_back(p);
  endtask

  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 131071 : -131072;
      1: return int'($urandom_range(0, 32)) - 16;
      2: return int'($urandom_range(0, 32768)) - 16384;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  // driver: a transfer happens at a rising edge with valid high and stall low
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(pose_q.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (pose_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_quat_x <= pose_q[0].qx; in_quat_y <= pose_q[0].qy;
          in_quat_z <= pose_q[0].qz; in_quat_w <= pose_q[0].qw;
          in_pos_x <= pose_q[0].px; in_pos_y <= pose_q[0].py;
          in_pos_z <= pose_q[0].pz;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // expectations are queued at the input transfer
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      matrix_q.push_back(rotation_of('{in_quat_x, in_quat_y, in_quat_z, in_quat_w,
                                       in_pos_x, in_pos_y, in_pos_z}));
    end
  end

  always @(posedge clk) begin
    xform_t m;
    logic signed [EW-1:0] got [9];
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_elem_0, out_elem_1, out_elem_2, out_elem_4, out_elem_5,
              out_elem_6, out_elem_8, out_elem_9, out_elem_10};
      if (matrix_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        m = matrix_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== m.e[i]) begin
            $error("elem_%0d expected %0d got %0d", i + i / 3, m.e[i], got[i]);
            errors++;
          end
        end
        if (out_trans_x !== m.tx) begin
          $error("trans_x expected %0d got %0d", m.tx, out_trans_x); errors++;
        end
        if (out_trans_y !== m.ty) begin
          $error("trans_y expected %0d got %0d", m.ty, out_trans_y); errors++;
        end
        if (out_trans_z !== m.tz) begin
          $error("trans_z expected %0d got %0d", m.tz, out_trans_z); errors++;
        end
      end
    end
  end

  task automatic wait_drain();
    while (pose_q.size() > 0 || matrix_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: zero quaternion, axes, extremes, ties
    push_pose(0, 0, 0, 0);
    push_pose(16384, 0, 0, 0);
    push_pose(0, 16384, 0, 0);
    push_pose(0, 0, 16384, 0);
    push_pose(0, 0, 0, 16384);
    push_pose(0, 0, 0, -16384);
    push_pose(1, 0, 0, 0);
    push_pose(0, 0, 0, -1);
    push_pose(131071, 131071, 131071, 131071);
    push_pose(-131072, -131072, -131072, -131072);
    push_pose(-131072, 131071, -131072, 131071);
    push_pose(131071, 0, 0, 0);
    push_pose(0, -131072, 0, 0);
    push_pose(1, 1, 1, 1);
    push_pose(1, -1, 1, -1);
    push_pose(3, 1, 0, 0);
    push_pose(11585, 0, 0, 11585);
    push_pose(-131072, 1, -1, 0);
    for (int i = 0; i < 4; i++) begin
      pose_t p;
      p.qx = QW'($urandom); p.qy = QW'($urandom);
      p.qz = QW'($urandom); p.qw = QW'($urandom);
      p.px = (i[0]) ? 32'h7fffffff : 32'h80000000;
      p.py = (i[1]) ? 32'hffffffff : 32'h0;
      p.pz = $urandom;
      pose_q.push_back(p);
    end
    for (int i = 0; i < 550; i++) push_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    // long receiver hold-off so the pipeline backs up into the input
    fork
      begin
        hold_on = 1'b1;
        repeat (60) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    wait_drain();
    send_idle_pct = 54; recv_idle_pct = 22;
    for (int i = 0; i < 550; i++) push_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    wait_drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 550; i++) push_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/qrm_pkg.sv
sv/qrm_prep.sv
sv/qrm_div_stage.sv
sv/qrm_round.sv
sv/quaternion_to_rotation_matrix.sv
sv/qrm_checker.sv
sim/quaternion_to_rotation_matrix_tb.sv
